@@ rtl/core/kle_pkg.sv @@
// Package of the keystroke line editor: sizes, key codes, command words,
// cell and command-event types and the command word matcher.
// Used by kle_cell, kle_cmd and keystroke_line_editor_top.
`timescale 1ns / 1ps

package kle_pkg;

  localparam int LINE_DEPTH    = 64;
  localparam int LEN_W         = $clog2(LINE_DEPTH + 1);
  localparam int CMD_CHARS     = 6;
  localparam int CMD_CNT_W     = 3;
  localparam int CMD_IDX_W     = $clog2(CMD_CHARS);

  localparam logic [CMD_CNT_W-1:0] CMD_OVERLONG = 3'd7;
  localparam logic [7:0]           KEY_OPEN     = 8'h3C;
  localparam logic [7:0]           KEY_CLOSE    = 8'h3E;

  typedef logic [CMD_CHARS-1:0][7:0] cmd_text_t;

  // Command words, with the first character in element zero.
  localparam cmd_text_t WORD_LEFT   = cmd_text_t'({16'h0000, "tfel"});
  localparam cmd_text_t WORD_RIGHT  = cmd_text_t'({8'h00, "thgir"});
  localparam cmd_text_t WORD_BSPACE = cmd_text_t'("ecapsb");
  localparam cmd_text_t WORD_DELETE = cmd_text_t'("eteled");

  localparam logic [CMD_CNT_W-1:0] LEN_LEFT   = 3'd4;
  localparam logic [CMD_CNT_W-1:0] LEN_RIGHT  = 3'd5;
  localparam logic [CMD_CNT_W-1:0] LEN_BSPACE = 3'd6;
  localparam logic [CMD_CNT_W-1:0] LEN_DELETE = 3'd6;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [LEN_W-1:0] pos;
    logic [7:0]      key;
  } cell_ctl_t;

  typedef struct packed {
    logic ins;
    logic left;
    logic right;
    logic bspace;
    logic del;
  } cmd_ev_t;

  function automatic logic cmd_match(cmd_text_t text, logic [CMD_CNT_W-1:0] cnt,
                                     cmd_text_t word, logic [CMD_CNT_W-1:0] len);
    logic hit;
    hit = (cnt == len);
    for (int i = 0; i < CMD_CHARS; i++) begin
      if ((CMD_CNT_W'(i) < len) && (text[i] != word[i])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

@@ rtl/core/keystroke_line_editor_top.sv @@
// Top level of the keystroke line editor: a row of byte cells, the command
// capture unit and the edit/readout controller. Depends on kle_pkg, kle_cell, kle_cmd.
//
//   channel   dir  tdata          tlast       tuser
//   s_axis    in   key_byte[7:0]  end_of_line -
//   m_axis    out  text_byte[7:0] last_byte   [0] line_empty, [1] overflowed
//
// Each keystroke beat is decoded as it is taken; the cell row shifts in that same cycle.
// A beat with tlast passes through a flush state that closes a pending command, then the
// line is read out from cell zero, one beat per byte (one beat for an empty line).
// The input is stalled during that readout; a stalled output beat holds.
// Reset clears the length, cursor, command and drop state; cell bytes are not reset.
`timescale 1ns / 1ps

module keystroke_line_editor_top
  import kle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] key_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] text_byte
  output logic       m_axis_tlast_o,
  output logic [1:0] m_axis_tuser_o    // [0] line_empty, [1] overflowed
);

  typedef enum logic [1:0] {
    ST_EDIT,
    ST_FLUSH,
    ST_READ
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cur_q, cur_d;
  logic             drop_q, drop_d;
  logic             s_fire, m_fire;
  cmd_ev_t          ev;
  cell_ctl_t        ctl;
  logic [7:0]       cell_data [LINE_DEPTH];

  assign s_axis_tready_o = (state_q == ST_EDIT);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == ST_READ);
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;

  kle_cmd u_cmd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (s_fire),
    .key_i       (s_axis_tdata_i),
    .flush_i     (state_q == ST_FLUSH),
    .ev_o        (ev)
  );

  for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
    logic [7:0] left_b, right_b;
    if (g == 0) begin : g_first
      assign left_b = '0;
    end else begin : g_inner_l
      assign left_b = cell_data[g-1];
    end
    if (g == LINE_DEPTH - 1) begin : g_last
      assign right_b = '0;
    end else begin : g_inner_r
      assign right_b = cell_data[g+1];
    end
    kle_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (LEN_W'(g)),
      .ctl_i   (ctl),
      .left_i  (left_b),
      .right_i (right_b),
      .data_o  (cell_data[g])
    );
  end

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    cur_d   = cur_q;
    drop_d  = drop_q;
    ctl.op  = CELL_HOLD;
    ctl.pos = cur_q;
    ctl.key = s_axis_tdata_i;
    if (ev.ins) begin
      if (len_q == LEN_W'(LINE_DEPTH)) begin
        drop_d = 1'b1;
      end else begin
        ctl.op = CELL_INS;
        len_d  = len_q + 1'b1;
        cur_d  = cur_q + 1'b1;
      end
    end
    if (ev.left && (cur_q != '0)) begin
      cur_d = cur_q - 1'b1;
    end
    if (ev.right && (cur_q < len_q)) begin
      cur_d = cur_q + 1'b1;
    end
    if (ev.bspace && (cur_q != '0)) begin
      cur_d   = cur_q - 1'b1;
      ctl.op  = CELL_DEL;
      ctl.pos = cur_q - 1'b1;
      len_d   = len_q - 1'b1;
    end
    if (ev.del && (cur_q < len_q)) begin
      ctl.op = CELL_DEL;
      len_d  = len_q - 1'b1;
    end
    unique case (state_q)
      ST_EDIT: begin
        if (s_fire && s_axis_tlast_i) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_READ;
      ST_READ: begin
        if (m_fire) begin
          ctl.op  = CELL_DEL;
          ctl.pos = '0;
          if (len_q <= LEN_W'(1)) begin
            len_d   = '0;
            cur_d   = '0;
            drop_d  = 1'b0;
            state_d = ST_EDIT;
          end else begin
            len_d = len_q - 1'b1;
          end
        end
      end
      default: state_d = ST_EDIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EDIT;
      len_q   <= '0;
      cur_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      drop_q  <= drop_d;
    end
  end

  assign m_axis_tdata_o    = (len_q == '0) ? 8'h00 : cell_data[0];
  assign m_axis_tlast_o    = (len_q <= LEN_W'(1));
  assign m_axis_tuser_o[0] = (len_q == '0);
  assign m_axis_tuser_o[1] = drop_q;

`ifndef SYNTHESIS
  a_cursor_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) || (cur_q <= len_q)) else $error("cursor beyond line length");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(LINE_DEPTH)) else $error("line length beyond depth");

  a_sides_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o)) else $error("input taken during readout");

  a_cleared_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast_o) |=> (len_q == '0 && !drop_q && s_axis_tready_o))
    else $error("line not cleared after last beat");
`endif

endmodule

@@ rtl/core/kle_cell.sv @@
// One byte cell of the line: holds, takes its left neighbor on insert (the key at the insert
// position), or its right neighbor on removal and readout shift. Depends on kle_pkg.
`timescale 1ns / 1ps

module kle_cell
  import kle_pkg::*;
(
  input  logic             clk_i,
  input  logic [LEN_W-1:0] idx_i,
  input  cell_ctl_t        ctl_i,
  input  logic [7:0]       left_i,
  input  logic [7:0]       right_i,
  output logic [7:0]       data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.op)
      CELL_INS: begin
        if (idx_i > ctl_i.pos) begin
          data_d = left_i;
        end else if (idx_i == ctl_i.pos) begin
          data_d = ctl_i.key;
        end
      end
      CELL_DEL: begin
        if (idx_i >= ctl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/kle_cmd.sv @@
// Command capture: tracks bracketed command text and decodes keystroke beats,
// or a flush, into insert or cursor/edit events. Depends on kle_pkg.
`timescale 1ns / 1ps

module kle_cmd
  import kle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       key_valid_i,
  input  logic [7:0] key_i,
  input  logic       flush_i,
  output cmd_ev_t    ev_o
);

  logic                 inside_q, inside_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  cmd_text_t            text_q;
  logic                 wr_en;
  logic                 run;

  always_comb begin
    inside_d = inside_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    run      = 1'b0;
    ev_o     = '0;
    if (key_valid_i) begin
      if (inside_q) begin
        if (key_i == KEY_CLOSE) begin
          run = 1'b1;
        end else if (cnt_q < CMD_CNT_W'(CMD_CHARS)) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          cnt_d = CMD_OVERLONG;
        end
      end else if (key_i == KEY_OPEN) begin
        inside_d = 1'b1;
        cnt_d    = '0;
      end else begin
        ev_o.ins = 1'b1;
      end
    end else if (flush_i && inside_q) begin
      run = 1'b1;
    end
    if (run) begin
      ev_o.left   = cmd_match(text_q, cnt_q, WORD_LEFT, LEN_LEFT);
      ev_o.right  = cmd_match(text_q, cnt_q, WORD_RIGHT, LEN_RIGHT);
      ev_o.bspace = cmd_match(text_q, cnt_q, WORD_BSPACE, LEN_BSPACE);
      ev_o.del    = cmd_match(text_q, cnt_q, WORD_DELETE, LEN_DELETE);
      inside_d    = 1'b0;
      cnt_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      inside_q <= inside_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      text_q[cnt_q[CMD_IDX_W-1:0]] <= key_i;
    end
  end

endmodule
